[rtl/asin_ts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asin_ts_pkg
// Shared widths, the multiplier request type and the arcsine coefficient ROM.
// ----------------------------------------------------------------------------
package asin_ts_pkg;

	localparam int IN_W      = 16;
	localparam int OUT_W     = 17;
	localparam int CNT_W     = 4;
	localparam int OP_W      = 31;
	localparam int PROD_W    = 2 * OP_W;
	localparam int INT_FRAC  = 30;
	localparam int FRAC_BITS = 15;
	localparam int SUM_W     = 35;
	localparam int MAG_W     = SUM_W - FRAC_BITS;
	localparam int MAX_TERMS = 16;

	localparam logic [CNT_W-1:0] TERM_RESET = CNT_W'(7);
	localparam logic [MAG_W-1:0] SAT_LIM    = MAG_W'(51472);

	typedef struct packed {
		logic            en;
		logic [OP_W-1:0] op_a;
		logic [OP_W-1:0] op_b;
	} mul_req_t;

	// c(n) = (2n)! / (4^n (n!)^2 (2n+1)), rounded to q1.30
	function automatic logic [OP_W-1:0] coef_rom(input logic [CNT_W-1:0] idx);
		logic [OP_W-1:0] c;
		case (idx)
			4'd0:    c = OP_W'(1073741824);
			4'd1:    c = OP_W'(178956971);
			4'd2:    c = OP_W'(80530637);
			4'd3:    c = OP_W'(47934903);
			4'd4:    c = OP_W'(32622364);
			4'd5:    c = OP_W'(24021923);
			4'd6:    c = OP_W'(18632389);
			4'd7:    c = OP_W'(14994637);
			4'd8:    c = OP_W'(12403652);
			4'd9:    c = OP_W'(10481448);
			4'd10:   c = OP_W'(9009054);
			4'd11:   c = OP_W'(7851765);
			4'd12:   c = OP_W'(6922639);
			4'd13:   c = OP_W'(6163319);
			4'd14:   c = OP_W'(5533324);
			4'd15:   c = OP_W'(5003791);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[rtl/asin_ts_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asin_ts_mul
// Shared unsigned 31x31 multiplier with a registered product.
// ----------------------------------------------------------------------------
module asin_ts_mul (
	input  logic                         clk,
	input  asin_ts_pkg::mul_req_t        req,
	output logic [asin_ts_pkg::PROD_W-1:0] prod
);

	logic [asin_ts_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= asin_ts_pkg::PROD_W'(req.op_a) * asin_ts_pkg::PROD_W'(req.op_b);
		end
	end

	assign prod = prod_q;

endmodule

[rtl/asin_ts_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asin_ts_seq
// Term sequencer: drives the shared multiplier, keeps power and sum, and
// rounds, saturates and signs the result into the output register.
// ----------------------------------------------------------------------------
module asin_ts_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [asin_ts_pkg::IN_W-1:0] x_in,
	input  logic [asin_ts_pkg::CNT_W-1:0]       last_term,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [asin_ts_pkg::OUT_W-1:0] series_sum,
	output asin_ts_pkg::mul_req_t               mul_req,
	input  logic [asin_ts_pkg::PROD_W-1:0]      prod
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_LX2,
		S_POW,
		S_COEF,
		S_FIN,
		S_RND
	} state_t;

	state_t                              state_q;
	logic                                neg_q;
	logic [asin_ts_pkg::IN_W-1:0]        a_q;
	logic [asin_ts_pkg::OP_W-1:0]        x2_q;
	logic [asin_ts_pkg::OP_W-1:0]        pw_q;
	logic [asin_ts_pkg::SUM_W-1:0]       sum_q;
	logic [asin_ts_pkg::CNT_W-1:0]       n_q;
	logic [asin_ts_pkg::CNT_W-1:0]       last_q;
	logic                                out_valid_q;
	logic signed [asin_ts_pkg::OUT_W-1:0] series_sum_q;

	logic [asin_ts_pkg::IN_W-1:0]        a_in;
	logic [asin_ts_pkg::OP_W+0:0]        prod_rnd;
	logic [asin_ts_pkg::MAG_W-1:0]       mag;
	logic [asin_ts_pkg::MAG_W-1:0]       mag_sat;
	logic [asin_ts_pkg::OUT_W-1:0]       res;

	assign a_in = x_in[asin_ts_pkg::IN_W-1] ? asin_ts_pkg::IN_W'(-x_in)
	                                        : asin_ts_pkg::IN_W'(x_in);

	// product rounded half up from q.60 to q.30
	assign prod_rnd = prod[asin_ts_pkg::PROD_W-1:asin_ts_pkg::INT_FRAC]
	                + (asin_ts_pkg::OP_W+1)'(prod[asin_ts_pkg::INT_FRAC-1]);

	always_comb begin
		mag = sum_q[asin_ts_pkg::SUM_W-1:asin_ts_pkg::FRAC_BITS]
		    + asin_ts_pkg::MAG_W'(sum_q[asin_ts_pkg::FRAC_BITS-1]);
		mag_sat = (mag > asin_ts_pkg::SAT_LIM) ? asin_ts_pkg::SAT_LIM : mag;
		res = neg_q ? asin_ts_pkg::OUT_W'(-mag_sat) : asin_ts_pkg::OUT_W'(mag_sat);
	end

	always_comb begin
		mul_req = '0;
		case (state_q)
			S_SQ: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = asin_ts_pkg::OP_W'(a_q);
				mul_req.op_b = asin_ts_pkg::OP_W'(a_q);
			end
			S_POW: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = pw_q;
				mul_req.op_b = x2_q;
			end
			S_COEF: begin
				mul_req.en   = 1'b1;
				mul_req.op_a = asin_ts_pkg::coef_rom(n_q);
				mul_req.op_b = pw_q;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			neg_q        <= 1'b0;
			a_q          <= '0;
			x2_q         <= '0;
			pw_q         <= '0;
			sum_q        <= '0;
			n_q          <= '0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
			series_sum_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_RND)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						neg_q   <= x_in[asin_ts_pkg::IN_W-1];
						a_q     <= a_in;
						pw_q    <= {a_in, asin_ts_pkg::FRAC_BITS'(0)};
						sum_q   <= '0;
						n_q     <= '0;
						last_q  <= last_term;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_LX2;
				end
				S_LX2: begin
					x2_q    <= prod[asin_ts_pkg::OP_W-1:0];
					state_q <= S_POW;
				end
				S_POW: begin
					// previous term product lands here
					if (n_q != '0) begin
						sum_q <= sum_q + asin_ts_pkg::SUM_W'(prod_rnd);
					end
					state_q <= S_COEF;
				end
				S_COEF: begin
					pw_q <= prod_rnd[asin_ts_pkg::OP_W-1:0];
					if (n_q == last_q) begin
						state_q <= S_FIN;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_POW;
					end
				end
				S_FIN: begin
					sum_q   <= sum_q + asin_ts_pkg::SUM_W'(prod_rnd);
					state_q <= S_RND;
				end
				S_RND: begin
					if (!(out_valid_q && out_stall)) begin
						series_sum_q <= res;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign series_sum = series_sum_q;

endmodule

[rtl/arcsin_taylor_series_core.sv]
`timescale 1ns / 1ps
// sequence: square x, then per term a power and a coefficient pass, then final sum
// and rounding into the output register; a new input is taken only in idle
// each term takes two passes through the one shared 31x31 multiplier
// reset: async active low, sequencer idle, output empty, term_count = 7
// ----------------------------------------------------------------------------
// arcsin_taylor_series_core
// Arcsine Maclaurin partial sum of a q1.15 input, saturated q.15 result.
// ----------------------------------------------------------------------------
module arcsin_taylor_series_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [asin_ts_pkg::CNT_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [asin_ts_pkg::IN_W-1:0]  x_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [asin_ts_pkg::OUT_W-1:0] series_sum
);

	logic [asin_ts_pkg::CNT_W-1:0]  term_count_q;
	asin_ts_pkg::mul_req_t          mul_req;
	logic [asin_ts_pkg::PROD_W-1:0] prod;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= asin_ts_pkg::TERM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			term_count_q <= cfg_data;
		end
	end

	asin_ts_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	asin_ts_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_in       (x_in),
		.last_term  (term_count_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.series_sum (series_sum),
		.mul_req    (mul_req),
		.prod       (prod)
	);

	// busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after input transfer");

	// multiplier idle while waiting for input
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !mul_req.en)
		else $error("multiplier active while idle");

	// result stays within the saturation range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (series_sum <= 17'sd51472) && (series_sum >= -17'sd51472))
		else $error("result outside saturation range");

endmodule
